[design/cigrb_pkg.sv]
// Shared types, constants and helpers for the CIGAR to reference block splitter.
package cigrb_pkg;

	localparam int POS_WIDTH = 40;
	localparam int SUM_W     = POS_WIDTH + 2;
	localparam int BLK_W     = 40;
	localparam int CODE_W    = 8;
	localparam int LEN_W     = 28;
	localparam int START_W   = 31;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	typedef logic [POS_WIDTH-1:0] pos_t;
	localparam pos_t POS_MAX = '1;

	// ASCII operation letters.
	localparam logic [CODE_W-1:0] OP_M  = 8'h4D;
	localparam logic [CODE_W-1:0] OP_I  = 8'h49;
	localparam logic [CODE_W-1:0] OP_D  = 8'h44;
	localparam logic [CODE_W-1:0] OP_N  = 8'h4E;
	localparam logic [CODE_W-1:0] OP_S  = 8'h53;
	localparam logic [CODE_W-1:0] OP_H  = 8'h48;
	localparam logic [CODE_W-1:0] OP_P  = 8'h50;
	localparam logic [CODE_W-1:0] OP_EQ = 8'h3D;
	localparam logic [CODE_W-1:0] OP_X  = 8'h58;

	// Register word index on the configuration port.
	typedef enum logic {
		REG_BREAK_DEL  = 1'b0,
		REG_BREAK_SKIP = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [CODE_W-1:0]  op_code;
		logic [LEN_W-1:0]   op_length;
		logic               first_op;
		logic               last_op;
		logic [START_W-1:0] align_start;
	} op_item_t;

	typedef struct packed {
		logic [BLK_W-1:0] block_start;
		logic [BLK_W-1:0] block_end;
		logic             final_block;
		logic             bad_op;
		logic             run_last;
	} blk_item_t;

	typedef struct packed {
		logic break_on_deletion;
		logic break_on_skip;
	} cfg_t;

	// Results produced by one processed op, written into the output queue.
	typedef struct packed {
		logic [1:0] count;
		blk_item_t  res0;
		blk_item_t  res1;
	} res_push_t;

	function automatic pos_t sat_pos(input logic [SUM_W-1:0] s);
		return (|s[SUM_W-1:POS_WIDTH]) ? POS_MAX : s[POS_WIDTH-1:0];
	endfunction

endpackage

[design/cigrb_regs.sv]
// Configuration register file behind the APB-style port.
module cigrb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cigrb_pkg::APB_AW-1:0] paddr,
	input  logic [cigrb_pkg::APB_DW-1:0] pwdata,
	output logic [cigrb_pkg::APB_DW-1:0] prdata,
	output logic                         pready,
	output cigrb_pkg::cfg_t              cfg
);
	import cigrb_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_BREAK_DEL:  cfg_q.break_on_deletion <= pwdata[0];
				REG_BREAK_SKIP: cfg_q.break_on_skip     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_BREAK_DEL:  prdata[0] = cfg_q.break_on_deletion;
			REG_BREAK_SKIP: prdata[0] = cfg_q.break_on_skip;
			default: ;
		endcase
	end

endmodule

[design/cigrb_step.sv]
// Input register, alignment state and the per-op block computation.
module cigrb_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cigrb_pkg::cfg_t       cfg,
	input  logic                  op_valid,
	output logic                  op_ready,
	input  cigrb_pkg::op_item_t   op_data,
	input  logic                  room,
	output cigrb_pkg::res_push_t  push
);
	import cigrb_pkg::*;

	logic     valid_s1;
	op_item_t item_s1;
	pos_t     cur_q;
	pos_t     pend_q;
	logic     drop_q;

	logic             fire;
	pos_t             eff_cur, eff_pend;
	logic             eff_drop;
	logic             is_ext, is_close, is_bad;
	logic [LEN_W-1:0] len_ext, len_all;
	logic [SUM_W-1:0] sum_all, sum_close, sum_pend;
	pos_t             end_all, end_close, pend_new;
	pos_t             cur_d, pend_d;
	logic             drop_d;

	assign fire     = valid_s1 & room;
	assign op_ready = ~valid_s1 | room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (op_ready) begin
			valid_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op_ready && op_valid) begin
			item_s1 <= op_data;
		end
	end

	// A first op restarts the alignment before the op itself is handled.
	always_comb begin
		eff_cur  = item_s1.first_op ? POS_WIDTH'(item_s1.align_start) : cur_q;
		eff_pend = item_s1.first_op ? '0 : pend_q;
		eff_drop = item_s1.first_op ? 1'b0 : drop_q;
	end

	always_comb begin
		is_ext   = 1'b0;
		is_close = 1'b0;
		is_bad   = 1'b0;
		case (item_s1.op_code) inside
			OP_M, OP_X, OP_EQ: is_ext = 1'b1;
			OP_I, OP_S, OP_P, OP_H: ;
			OP_D: begin
				is_close = cfg.break_on_deletion;
				is_ext   = ~cfg.break_on_deletion;
			end
			OP_N: begin
				is_close = cfg.break_on_skip;
				is_ext   = ~cfg.break_on_skip;
			end
			default: is_bad = 1'b1;
		endcase
	end

	// Saturation is monotone, so the nested clamps fold into one clamp of a
	// three-operand sum.
	assign len_ext   = is_ext ? item_s1.op_length : '0;
	assign len_all   = (is_ext | is_close) ? item_s1.op_length : '0;
	assign sum_all   = SUM_W'(eff_cur) + SUM_W'(eff_pend) + SUM_W'(len_all);
	assign sum_close = SUM_W'(eff_cur) + SUM_W'(eff_pend);
	assign sum_pend  = SUM_W'(eff_pend) + SUM_W'(len_ext);
	assign end_all   = sat_pos(sum_all);
	assign end_close = sat_pos(sum_close);
	assign pend_new  = sat_pos(sum_pend);

	always_comb begin
		push   = '0;
		cur_d  = eff_cur;
		pend_d = eff_pend;
		drop_d = eff_drop;
		if (eff_drop) begin
			drop_d = ~item_s1.last_op;
		end else if (is_bad) begin
			push.count        = 2'd1;
			push.res0.bad_op   = 1'b1;
			push.res0.run_last = 1'b1;
			pend_d            = '0;
			drop_d            = ~item_s1.last_op;
		end else if (is_close) begin
			push.res0.block_start = BLK_W'(eff_cur);
			push.res0.block_end   = BLK_W'(end_close);
			cur_d                 = end_all;
			pend_d                = '0;
			if (item_s1.last_op) begin
				push.count             = 2'd2;
				push.res1.block_start  = BLK_W'(end_all);
				push.res1.block_end    = BLK_W'(end_all);
				push.res1.final_block  = 1'b1;
				push.res1.run_last     = 1'b1;
			end else begin
				push.count         = 2'd1;
				push.res0.run_last = 1'b1;
			end
		end else if (item_s1.last_op) begin
			push.count            = 2'd1;
			push.res0.block_start = BLK_W'(eff_cur);
			push.res0.block_end   = BLK_W'(end_all);
			push.res0.final_block = 1'b1;
			push.res0.run_last    = 1'b1;
			cur_d                 = end_all;
			pend_d                = '0;
		end else begin
			pend_d = pend_new;
		end
		if (!fire) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			pend_q <= '0;
			drop_q <= 1'b0;
		end else if (fire) begin
			cur_q  <= cur_d;
			pend_q <= pend_d;
			drop_q <= drop_d;
		end
	end

`ifndef SYNTHESIS
	a_bad_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0 && push.res0.bad_op) |->
		(push.count == 2'd1 && push.res0.block_start == '0 &&
		 push.res0.block_end == '0 && !push.res0.final_block))
		else $error("error result carries block data");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |->
		(!push.res0.run_last && !push.res0.final_block &&
		 push.res1.run_last && push.res1.final_block))
		else $error("two-result op has wrong result flags");
	a_drop_set: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd1 && push.res0.bad_op && !item_s1.last_op) |=> drop_q)
		else $error("error inside an alignment did not start dropping");
`endif

endmodule

[design/cigrb_outq.sv]
// Small result queue that takes up to two results a cycle and hands out one.
module cigrb_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cigrb_pkg::res_push_t  push,
	output logic                  room,
	output logic                  blk_valid,
	input  logic                  blk_ready,
	output cigrb_pkg::blk_item_t  blk_data
);
	import cigrb_pkg::*;

	blk_item_t         ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;

	assign room      = cnt_q <= QCNT_W'(QDEPTH - 2);
	assign blk_valid = cnt_q != '0;
	assign blk_data  = ent_q[rd_ptr_q];
	assign pop       = blk_valid & blk_ready;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			ent_q[wr_ptr_q] <= push.res0;
		end
		if (push.count == 2'd2) begin
			ent_q[wr_ptr_q + QPTR_W'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			cnt_q    <= cnt_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> cnt_q <= QCNT_W'(QDEPTH - 2))
		else $error("result pushed without room for two");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue count out of range");
`endif

endmodule

[design/cigar_to_reference_blocks.sv]
// Top level of the CIGAR to reference block splitter.
//
// One CIGAR operation enters per op transfer (op_valid/op_ready, payload
// op_data); the first op of an alignment carries its reference start. Each
// op yields zero, one or two block transfers on blk_valid/blk_ready: a
// closed block when a deletion or skip closes the pending block, the final
// block on the alignment's last op, or one error result for an unknown op
// code, after which the rest of the alignment yields nothing. Positions and
// lengths saturate at the all-ones value of the position width.
// An op is held in an input register and processed from there once the
// four-entry result queue has room for two results; its first result is
// offered once the op's results have been written into the result queue.
// The block takes one op per cycle while the queue has room; the output
// side moves one result per cycle while the receiver is ready, so the two
// results of an op leave one after the other. When the receiver stalls the
// queue fills and op_ready drops; nothing is lost or repeated.
// Reset clears the alignment state, the queue and both mode registers.
// The mode registers sit on the APB-style port at byte addresses 0 and 4
// and must be written by the user only while the block is idle; the block has no check for this.
module cigar_to_reference_blocks (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cigrb_pkg::APB_AW-1:0] paddr,
	input  logic [cigrb_pkg::APB_DW-1:0] pwdata,
	output logic [cigrb_pkg::APB_DW-1:0] prdata,
	output logic                         pready,
	input  logic                         op_valid,
	output logic                         op_ready,
	input  cigrb_pkg::op_item_t          op_data,
	output logic                         blk_valid,
	input  logic                         blk_ready,
	output cigrb_pkg::blk_item_t         blk_data
);
	import cigrb_pkg::*;

	cfg_t      cfg;
	res_push_t push;
	logic      room;

	// Mode registers.
	cigrb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register and the single-pass block computation.
	cigrb_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op_data  (op_data),
		.room     (room),
		.push     (push)
	);

	// Result queue that decouples the receiver from the op stream.
	cigrb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.blk_valid (blk_valid),
		.blk_ready (blk_ready),
		.blk_data  (blk_data)
	);

endmodule
